/* src/sddw_pkg.sv */
// ============================================================================
// sddw_pkg
// Shared types, constants and helpers for the signed decimal display writer.
// ============================================================================
package sddw_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIGITS_DEF = 8;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths
    localparam int ADDR_W       = 4;
    localparam int CODE_W       = 8;
    localparam int CFG_DIGITS_W = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int BCD_W1       = 4;
    localparam int OUT_TDATA_W  = 16;

    // Binary bits folded into the BCD accumulator per pipeline stage
    localparam int DABBLE_BITS = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUS_CODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CODE     = 2'd3;

    // Reset values of the configuration registers
    localparam logic [CFG_DIGITS_W-1:0] RST_DIGITS_IN_USE = 4'd8;
    localparam logic [CODE_W-1:0]       RST_BLANK_CODE    = 8'd15;
    localparam logic [CODE_W-1:0]       RST_MINUS_CODE    = 8'd10;
    localparam logic [CODE_W-1:0]       RST_ZERO_CODE     = 8'd62;

    typedef struct packed {
        logic [CFG_DIGITS_W-1:0] digits_in_use;
        logic [CODE_W-1:0]       blank_code;
        logic [CODE_W-1:0]       minus_code;
        logic [CODE_W-1:0]       zero_code;
    } t_cfg;

    // Decimal digits needed for an unsigned number of the given bit count
    function automatic int f_bcd_digits(input int bits);
        return (bits * 30103) / 100000 + 1;
    endfunction

    // Number of dabble stages for the given value width
    function automatic int f_num_stages(input int bits);
        return (bits + DABBLE_BITS - 1) / DABBLE_BITS;
    endfunction

endpackage

/* src/sddw_dabble_stage.sv */
// ============================================================================
// sddw_dabble_stage
// One register stage of the binary to BCD shift-and-add-3 pipeline.
// ============================================================================
module sddw_dabble_stage #(
    parameter int VALUE_BITS = sddw_pkg::VALUE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic [sddw_pkg::f_num_stages(VALUE_BITS)*sddw_pkg::DABBLE_BITS-1:0] i_bin,
    input  logic [sddw_pkg::f_bcd_digits(VALUE_BITS)*sddw_pkg::BCD_W1-1:0]      i_bcd,
    input  logic i_neg,
    output logic o_valid,
    input  logic i_ready,
    output logic [sddw_pkg::f_num_stages(VALUE_BITS)*sddw_pkg::DABBLE_BITS-1:0] o_bin,
    output logic [sddw_pkg::f_bcd_digits(VALUE_BITS)*sddw_pkg::BCD_W1-1:0]      o_bcd,
    output logic o_neg
);
    import sddw_pkg::*;

    localparam int PAD_BITS   = f_num_stages(VALUE_BITS) * DABBLE_BITS;
    localparam int BCD_DIGITS = f_bcd_digits(VALUE_BITS);
    localparam int BCD_W      = BCD_DIGITS * BCD_W1;

    logic                r_valid;
    logic [PAD_BITS-1:0] r_bin;
    logic [BCD_W-1:0]    r_bcd;
    logic                r_neg;
    logic [PAD_BITS-1:0] n_bin;
    logic [BCD_W-1:0]    n_bcd;

    assign o_ready = !r_valid || i_ready;

    // Fold the top DABBLE_BITS binary bits into the decimal accumulator
    always_comb begin
        n_bin = i_bin;
        n_bcd = i_bcd;
        for (int s = 0; s < DABBLE_BITS; s++) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (n_bcd[d*BCD_W1 +: BCD_W1] >= 4'd5) begin
                    n_bcd[d*BCD_W1 +: BCD_W1] = n_bcd[d*BCD_W1 +: BCD_W1] + 4'd3;
                end
            end
            n_bcd = {n_bcd[BCD_W-2:0], n_bin[PAD_BITS-1]};
            n_bin = {n_bin[PAD_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
            r_neg <= i_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_bin   = r_bin;
    assign o_bcd   = r_bcd;
    assign o_neg   = r_neg;

endmodule

/* src/sddw_emitter.sv */
// ============================================================================
// sddw_emitter
// Digit analysis stage, write sequencer and output register.
// ============================================================================
module sddw_emitter #(
    parameter int VALUE_BITS = sddw_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = sddw_pkg::MAX_DIGITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sddw_pkg::t_cfg         i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [sddw_pkg::f_bcd_digits(VALUE_BITS)*sddw_pkg::BCD_W1-1:0] i_bcd,
    input  logic                   i_neg,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [sddw_pkg::ADDR_W-1:0] o_addr,
    output logic [sddw_pkg::CODE_W-1:0] o_data,
    output logic                   o_last,
    output logic                   o_overflow
);
    import sddw_pkg::*;

    localparam int BCD_DIGITS = f_bcd_digits(VALUE_BITS);
    localparam int BCD_W      = BCD_DIGITS * BCD_W1;
    localparam int EXT_DIGITS = (BCD_DIGITS > MAX_DIGITS) ? BCD_DIGITS : MAX_DIGITS + 1;
    localparam int EXT_W      = EXT_DIGITS * BCD_W1;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int K_W        = $clog2(2 * MAX_DIGITS + 1);
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // ---------------- analysis ----------------
    logic [EXT_W-1:0]      ext;
    logic [CNT_W-1:0]      n_cnt;
    logic [MAX_DIGITS:0]   hi_nz;
    logic [CNT_W-1:0]      nz_cnt;
    logic                  sign_fits;
    logic                  hi_below;
    logic                  is_zero;
    logic [CNT_W-1:0]      wcount;

    logic                  r_an_valid;
    logic [CNT_W-1:0]      r_an_n;
    logic [CNT_W-1:0]      r_an_ndig;
    logic [K_W-1:0]        r_an_total;
    logic                  r_an_zero;
    logic                  r_an_dropped;
    logic [BCD_W1-1:0]     r_an_digit [MAX_DIGITS];

    // ---------------- sequencer ----------------
    logic                  r_sq_busy;
    logic [K_W-1:0]        r_sq_k;
    logic [K_W-1:0]        r_sq_total;
    logic [CNT_W-1:0]      r_sq_n;
    logic [CNT_W-1:0]      r_sq_ndig;
    logic                  r_sq_zero;
    logic                  r_sq_dropped;
    logic [BCD_W1-1:0]     r_sq_digit [MAX_DIGITS];

    logic                  r_out_valid;
    logic [ADDR_W-1:0]     r_out_addr;
    logic [CODE_W-1:0]     r_out_data;
    logic                  r_out_last;
    logic                  r_out_ovf;

    logic                  out_free;
    logic                  emit;
    logic                  is_last;
    logic                  seq_load;
    logic [K_W-1:0]        kk;
    logic [CNT_W-1:0]      pos;
    logic [ADDR_W-1:0]     n_addr;
    logic [CODE_W-1:0]     n_data;

    // Clamp digit count and locate the highest nonzero decimal digit
    always_comb begin
        ext = EXT_W'(i_bcd);
        if (i_cfg.digits_in_use == '0) begin
            n_cnt = CNT_W'(1);
        end else if (i_cfg.digits_in_use > CFG_DIGITS_W'(MAX_DIGITS)) begin
            n_cnt = CNT_W'(MAX_DIGITS);
        end else begin
            n_cnt = CNT_W'(i_cfg.digits_in_use);
        end
        for (int i = 0; i <= MAX_DIGITS; i++) begin
            hi_nz[i] = |(ext >> (BCD_W1 * i));
        end
        nz_cnt = '0;
        for (int p = 0; p < MAX_DIGITS; p++) begin
            if (hi_nz[p] && (CNT_W'(p) < n_cnt)) begin
                nz_cnt = nz_cnt + CNT_W'(1);
            end
        end
        hi_below  = hi_nz[n_cnt - CNT_W'(1)];
        is_zero   = !hi_nz[0];
        sign_fits = i_neg && !hi_below;
        wcount    = is_zero ? CNT_W'(1) : nz_cnt + CNT_W'(sign_fits);
    end

    assign out_free = !r_out_valid || i_ready;
    assign emit     = r_sq_busy && out_free;
    assign is_last  = (r_sq_k == r_sq_total - K_W'(1));
    assign seq_load = r_an_valid && (!r_sq_busy || (emit && is_last));
    assign o_ready  = !r_an_valid || seq_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_an_valid <= 1'b0;
        end else if (o_ready) begin
            r_an_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_an_n       <= n_cnt;
            r_an_ndig    <= nz_cnt;
            r_an_total   <= K_W'(n_cnt) + K_W'(wcount);
            r_an_zero    <= is_zero;
            r_an_dropped <= hi_nz[n_cnt] || (i_neg && hi_below);
            for (int p = 0; p < MAX_DIGITS; p++) begin
                r_an_digit[p] <= ext[p*BCD_W1 +: BCD_W1];
            end
        end
    end

    // Decode the current write: blanks from the top down, then digits and sign
    always_comb begin
        kk  = r_sq_k - K_W'(r_sq_n);
        pos = CNT_W'(kk);
        if (r_sq_k < K_W'(r_sq_n)) begin
            n_addr = ADDR_W'(K_W'(r_sq_n) - r_sq_k);
            n_data = i_cfg.blank_code;
        end else if (r_sq_zero) begin
            n_addr = ADDR_W'(1);
            n_data = i_cfg.zero_code;
        end else if (pos < r_sq_ndig) begin
            n_addr = ADDR_W'(pos) + ADDR_W'(1);
            n_data = CODE_W'(r_sq_digit[IDX_W'(pos)]);
        end else begin
            n_addr = ADDR_W'(pos) + ADDR_W'(1);
            n_data = i_cfg.minus_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_k    <= '0;
        end else if (seq_load) begin
            r_sq_busy <= 1'b1;
            r_sq_k    <= '0;
        end else if (emit && is_last) begin
            r_sq_busy <= 1'b0;
        end else if (emit) begin
            r_sq_k <= r_sq_k + K_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_load) begin
            r_sq_total   <= r_an_total;
            r_sq_n       <= r_an_n;
            r_sq_ndig    <= r_an_ndig;
            r_sq_zero    <= r_an_zero;
            r_sq_dropped <= r_an_dropped;
            r_sq_digit   <= r_an_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_addr <= n_addr;
            r_out_data <= n_data;
            r_out_last <= is_last;
            r_out_ovf  <= is_last && r_sq_dropped;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_addr     = r_out_addr;
    assign o_data     = r_out_data;
    assign o_last     = r_out_last;
    assign o_overflow = r_out_ovf;

endmodule

/* src/signed_decimal_digit_display_writer_top.sv */
// ============================================================================
// signed_decimal_digit_display_writer_top
// Turns signed numbers into runs of seven-segment digit register writes.
// ============================================================================
// Usage:
//   Slave stream: one request per number, tdata holds the two's complement
//   value. Master stream: one request per digit register write; tdata holds
//   the register address (1 = least significant digit), the data code and
//   the overflow flag; tlast marks the final write of a number's run.
//   Each run first blanks digits n..1 (n = digits_in_use, clamped to
//   1..MAX_DIGITS), then writes the zero code to digit 1 for zero, or the
//   decimal digits least significant first plus a minus code for negative
//   numbers. Digits or a sign past digit n are dropped; overflow then marks the last write.
//   Path: an input request reaches the first write through the input
//   register, the binary to BCD pipeline of four bits per stage, the
//   analysis register, the write sequencer and the output register.
//   Throughput: one write per cycle while the receiver is ready; a number
//   takes n + 1 to 2n writes (2 to 16), issued by the single write
//   sequencer. Up to NUM_STAGES + 2 further numbers are buffered in the
//   pipeline meanwhile.
//   Reset (i_rst_n low, synchronous) empties the pipeline and loads the
//   register defaults. When the receiver stalls, the output write holds and
//   the pipeline fills, then drops tready on the slave side.
//   Write configuration registers only while no number is in flight.
// ============================================================================
module signed_decimal_digit_display_writer_top #(
    parameter int VALUE_BITS = sddw_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = sddw_pkg::MAX_DIGITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [sddw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sddw_pkg::CODE_W-1:0]     i_cfg_data,
    // slave stream
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // [VALUE_BITS-1:0] value, zero padded to whole bytes
    input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // master stream
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // [3:0] reg_addr, [11:4] reg_data, [12] overflow, [15:13] zero
    output logic [sddw_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic o_m_axis_tlast
);
    import sddw_pkg::*;

    localparam int NUM_STAGES = f_num_stages(VALUE_BITS);
    localparam int PAD_BITS   = NUM_STAGES * DABBLE_BITS;
    localparam int BCD_W      = f_bcd_digits(VALUE_BITS) * BCD_W1;

    // Configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.digits_in_use <= RST_DIGITS_IN_USE;
            r_cfg.blank_code    <= RST_BLANK_CODE;
            r_cfg.minus_code    <= RST_MINUS_CODE;
            r_cfg.zero_code     <= RST_ZERO_CODE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIGITS_IN_USE: r_cfg.digits_in_use <= i_cfg_data[CFG_DIGITS_W-1:0];
                CFG_BLANK_CODE:    r_cfg.blank_code    <= i_cfg_data;
                CFG_MINUS_CODE:    r_cfg.minus_code    <= i_cfg_data;
                CFG_ZERO_CODE:     r_cfg.zero_code     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage links: index 0 is the input register, NUM_STAGES the last dabble
    logic                st_valid [NUM_STAGES + 1];
    logic                st_ready [NUM_STAGES + 1];
    logic [PAD_BITS-1:0] st_bin   [NUM_STAGES + 1];
    logic [BCD_W-1:0]    st_bcd   [NUM_STAGES + 1];
    logic                st_neg   [NUM_STAGES + 1];

    // Input register: take sign and magnitude; the most negative value
    // negates to its own unsigned magnitude, so no bit is lost.
    logic                  r_in_valid;
    logic [PAD_BITS-1:0]   r_in_mag;
    logic                  r_in_neg;
    logic [VALUE_BITS-1:0] in_value;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;

    assign in_value        = i_s_axis_tdata[VALUE_BITS-1:0];
    assign in_neg          = in_value[VALUE_BITS-1];
    assign in_mag          = in_neg ? (~in_value + VALUE_BITS'(1)) : in_value;
    assign o_s_axis_tready = !r_in_valid || st_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_mag <= PAD_BITS'(in_mag);
            r_in_neg <= in_neg;
        end
    end

    assign st_valid[0] = r_in_valid;
    assign st_bin[0]   = r_in_mag;
    assign st_bcd[0]   = '0;
    assign st_neg[0]   = r_in_neg;

    // Binary to BCD pipeline
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
        sddw_dabble_stage #(
            .VALUE_BITS (VALUE_BITS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .o_ready (st_ready[g]),
            .i_bin   (st_bin[g]),
            .i_bcd   (st_bcd[g]),
            .i_neg   (st_neg[g]),
            .o_valid (st_valid[g+1]),
            .i_ready (st_ready[g+1]),
            .o_bin   (st_bin[g+1]),
            .o_bcd   (st_bcd[g+1]),
            .o_neg   (st_neg[g+1])
        );
    end

    // Analysis, write sequencing and output register
    logic [ADDR_W-1:0] out_addr;
    logic [CODE_W-1:0] out_data;
    logic              out_ovf;

    sddw_emitter #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (st_valid[NUM_STAGES]),
        .o_ready    (st_ready[NUM_STAGES]),
        .i_bcd      (st_bcd[NUM_STAGES]),
        .i_neg      (st_neg[NUM_STAGES]),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_addr     (out_addr),
        .o_data     (out_data),
        .o_last     (o_m_axis_tlast),
        .o_overflow (out_ovf)
    );

    assign o_m_axis_tdata = {3'b000, out_ovf, out_data, out_addr};

    // Assertions
    a_ovf_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[12]) |-> o_m_axis_tlast)
        else $error("overflow flag raised on a write that is not the last");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[3:0] != '0) &&
                             (o_m_axis_tdata[3:0] <= ADDR_W'(MAX_DIGITS))))
        else $error("digit address outside 1..MAX_DIGITS");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("write request right after reset");

endmodule
